/* sv/tsps_pkg.sv */
// shared types and constants of the three-axis step pulse scheduler
// request and result structs, command codes, axis count and timer constants
// no dependencies

package tsps_pkg;

  localparam int unsigned AXIS_COUNT = 3;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned COUNT_W    = 32;

  localparam logic [TIME_W-1:0] NEVER_TIME = 32'hFFFF_FFFF;

  // command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  typedef struct packed {
    logic                  command;
    logic [COUNT_W-1:0]    steps_x;
    logic [COUNT_W-1:0]    steps_y;
    logic [COUNT_W-1:0]    steps_z;
    logic [TIME_W-1:0]     period_x;
    logic [TIME_W-1:0]     period_y;
    logic [TIME_W-1:0]     period_z;
    logic [AXIS_COUNT-1:0] direction_in;
    logic [AXIS_COUNT-1:0] limit_blocked;
  } in_req_t;

  typedef struct packed {
    logic [AXIS_COUNT-1:0] step_mask;
    logic [AXIS_COUNT-1:0] direction_out;
    logic                  busy_res;
    logic                  move_done;
  } out_res_t;

  // per-axis status handed to the top level
  typedef struct packed {
    logic pulse;     // step pulse given on this tick
    logic busy_cur;  // steps left before this request
    logic busy_nxt;  // steps left after this request
  } axis_status_t;

endpackage

/* sv/tsps_axis.sv */
// one axis of the step pulse scheduler: step count, period and event time
// depends on tsps_pkg

module tsps_axis import tsps_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               tick,
  input  logic [COUNT_W-1:0] ld_steps,
  input  logic [TIME_W-1:0]  ld_period,
  input  logic [TIME_W-1:0]  elapsed_inc,
  input  logic               blocked,
  output axis_status_t       status
);

  logic [COUNT_W-1:0] steps_r, steps_nxt;
  logic [TIME_W-1:0]  period_r, period_nxt;
  logic [TIME_W-1:0]  event_r, event_nxt;
  logic [COUNT_W-1:0] steps_dec;
  logic               has_steps;
  logic               fire;

  assign has_steps = (steps_r != '0);
  assign steps_dec = steps_r - COUNT_W'(1);
  assign fire      = tick && has_steps && (elapsed_inc >= event_r);

  always_comb begin
    steps_nxt  = steps_r;
    period_nxt = period_r;
    event_nxt  = event_r;
    if (start) begin
      steps_nxt  = ld_steps;
      period_nxt = ld_period;
      event_nxt  = (ld_steps != '0) ? (ld_period >> 1) : NEVER_TIME;
    end else if (fire) begin
      steps_nxt = steps_dec;
      event_nxt = (steps_dec != '0) ? (event_r + period_r) : NEVER_TIME;
    end
  end

  assign status.pulse    = fire && !blocked;
  assign status.busy_cur = has_steps;
  assign status.busy_nxt = (steps_nxt != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_r  <= '0;
      period_r <= '0;
      event_r  <= NEVER_TIME;
    end else begin
      steps_r  <= steps_nxt;
      period_r <= period_nxt;
      event_r  <= event_nxt;
    end
  end

endmodule

/* sv/tsps_out_buf.sv */
// result register with a skid stage for the step pulse scheduler
// depends on tsps_pkg

module tsps_out_buf import tsps_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_en,
  input  out_res_t wr_res,
  output logic     full,
  output logic     out_valid,
  input  logic     out_stall,
  output out_res_t out_res
);

  logic     main_valid_r, main_valid_nxt;
  logic     skid_valid_r, skid_valid_nxt;
  out_res_t main_r, main_nxt;
  out_res_t skid_r, skid_nxt;
  logic     take;

  assign take = main_valid_r && !out_stall;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (take) begin
      if (skid_valid_r) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end else begin
        main_valid_nxt = 1'b0;
      end
    end
    // the writer must write only while the skid stage is empty; this block does not enforce it
    if (wr_en) begin
      if (!main_valid_r || take) begin
        main_nxt       = wr_res;
        main_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = wr_res;
        skid_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_res   = main_r;

endmodule

/* sv/three_axis_step_pulse_scheduler_unit.sv */
// top level of the three-axis step pulse scheduler
// depends on tsps_pkg, tsps_axis and tsps_out_buf

// usage
//   in_valid / in_stall / in_req carry one request: a start (load step counts,
//   periods and directions for all axes) or a one-microsecond tick
//   out_valid / out_stall / out_res carry one result per request: step mask,
//   latched directions, busy and move-done
// result: the result of a request is loaded into the result register, or into its
//   skid stage while an untaken result waits there, at the edge that accepts it
// throughput: one request per cycle while in_stall is low; the timer state is
//   updated at the accepting edge, limited by one 32-bit compare and add per axis
// stall: the result register has a skid stage behind it, so one more request
//   is taken while a result waits; in_stall rises only when both are full
//   and falls the cycle after the receiver takes a result
// reset (rst_n low, synchronous): elapsed count and step counts cleared,
//   event times set to never, directions cleared, no results pending
// a start while a move runs replaces it; a tick while idle returns an
//   all-zero mask with busy and done low

module three_axis_step_pulse_scheduler_unit import tsps_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_req,
  output logic     out_valid,
  input  logic     out_stall,
  output out_res_t out_res
);

  logic                  accept;
  logic                  start;
  logic                  tick;
  logic                  buf_full;
  logic [TIME_W-1:0]     elapsed_r, elapsed_nxt;
  logic [TIME_W-1:0]     elapsed_inc;
  logic [AXIS_COUNT-1:0] direction_r, direction_nxt;
  logic [COUNT_W-1:0]    ld_steps  [AXIS_COUNT];
  logic [TIME_W-1:0]     ld_period [AXIS_COUNT];
  axis_status_t          status    [AXIS_COUNT];
  logic [AXIS_COUNT-1:0] pulse_vec;
  logic [AXIS_COUNT-1:0] busy_cur_vec;
  logic [AXIS_COUNT-1:0] busy_nxt_vec;
  out_res_t              res;

  // a request is taken whenever the skid stage is free
  assign in_stall = buf_full;
  assign accept   = in_valid && !buf_full;
  assign start    = accept && (in_req.command == CMD_START);
  assign tick     = accept && (in_req.command == CMD_TICK);

  // elapsed time as seen by this tick's compares
  assign elapsed_inc = elapsed_r + TIME_W'(1);

  assign ld_steps[0]  = in_req.steps_x;
  assign ld_steps[1]  = in_req.steps_y;
  assign ld_steps[2]  = in_req.steps_z;
  assign ld_period[0] = in_req.period_x;
  assign ld_period[1] = in_req.period_y;
  assign ld_period[2] = in_req.period_z;

  for (genvar g = 0; g < AXIS_COUNT; g++) begin : g_axis
    tsps_axis u_axis (
      .clk         (clk),
      .rst_n       (rst_n),
      .start       (start),
      .tick        (tick),
      .ld_steps    (ld_steps[g]),
      .ld_period   (ld_period[g]),
      .elapsed_inc (elapsed_inc),
      .blocked     (in_req.limit_blocked[g]),
      .status      (status[g])
    );
    assign pulse_vec[g]    = status[g].pulse;
    assign busy_cur_vec[g] = status[g].busy_cur;
    assign busy_nxt_vec[g] = status[g].busy_nxt;
  end

  always_comb begin
    elapsed_nxt   = elapsed_r;
    direction_nxt = direction_r;
    if (start) begin
      elapsed_nxt   = '0;
      direction_nxt = in_req.direction_in;
    end else if (tick) begin
      elapsed_nxt = elapsed_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r   <= '0;
      direction_r <= '0;
    end else begin
      elapsed_r   <= elapsed_nxt;
      direction_r <= direction_nxt;
    end
  end

  // result of this request, built from the updated state
  always_comb begin
    res.step_mask     = pulse_vec;
    res.direction_out = direction_nxt;
    res.busy_res      = |busy_nxt_vec;
    // done only on the tick that uses up the last step
    res.move_done     = tick && (|busy_cur_vec) && !(|busy_nxt_vec);
  end

  tsps_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (accept),
    .wr_res    (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

endmodule
